// File: design/seg_int_pkg.sv
// Shared control type and default width constant for the segment intersection block.
package seg_int_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // Control that travels beside the datapath from the geometry stages onward.
  typedef struct packed {
    logic valid;
    logic hit;
    logic neg_x;
    logic neg_y;
  } seg_ctl_t;

endpackage

// File: design/seg_int_geom.sv
// Five-stage geometry front end: line equations, side tests, denominator, dividends.
module seg_int_geom
  import seg_int_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [8*COORD_WIDTH-1:0]   in_data,
  output seg_ctl_t                   ctl,
  output logic [2*COORD_WIDTH+2:0]   den_mag,
  output logic [3*COORD_WIDTH+3:0]   dvd_x,
  output logic [3*COORD_WIDTH+3:0]   dvd_y
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = 2*CW + 3;
  localparam int NW = 3*CW + 4;

  logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  assign ax = in_data[0*CW +: CW];
  assign ay = in_data[1*CW +: CW];
  assign bx = in_data[2*CW +: CW];
  assign by = in_data[3*CW +: CW];
  assign cx = in_data[4*CW +: CW];
  assign cy = in_data[5*CW +: CW];
  assign dx = in_data[6*CW +: CW];
  assign dy = in_data[7*CW +: CW];

  // Stage 1
  logic                   v1;
  logic signed [CW-1:0]   ax1, ay1, bx1, by1, cx1, cy1, dx1, dy1;
  logic signed [CW:0]     a1_1, b1_1, a2_1, b2_1;
  logic signed [2*CW-1:0] m1, m2, m3, m4;

  // Stage 2
  logic                   v2;
  logic signed [CW:0]     a1_2, b1_2, a2_2, b2_2;
  logic signed [2*CW:0]   c1_2, c2_2;
  logic signed [2*CW:0]   pa, pb, pc, pd, pe, pf, pg, ph;
  logic signed [2*CW+1:0] pd1, pd2;

  // Stage 3
  logic                   v3;
  logic signed [2*CW+3:0] sc, sd, sa, sb;
  logic signed [DW-1:0]   den3;
  logic signed [3*CW+1:0] n1, n2, n3, n4;

  // Stage 4
  logic                   v4, hit4, neg_den4;
  logic signed [3*CW+2:0] numx4, numy4;
  logic [DW-1:0]          dmag4;

  // Stage 5
  logic                   v5, hit5, negx5, negy5;
  logic [DW-1:0]          dmag5;
  logic [NW-1:0]          dx5, dy5;

  logic [3*CW+2:0]        absx4, absy4;
  logic                   same_cd, same_ab;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  assign same_cd = (sc != '0) && (sd != '0) && (sc[2*CW+3] == sd[2*CW+3]);
  assign same_ab = (sa != '0) && (sb != '0) && (sa[2*CW+3] == sb[2*CW+3]);
  assign absx4   = numx4[3*CW+2] ? (3*CW+3)'(-numx4) : (3*CW+3)'(numx4);
  assign absy4   = numy4[3*CW+2] ? (3*CW+3)'(-numy4) : (3*CW+3)'(numy4);

  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= ax; ay1 <= ay; bx1 <= bx; by1 <= by;
      cx1 <= cx; cy1 <= cy; dx1 <= dx; dy1 <= dy;
      a1_1 <= (CW+1)'(by) - (CW+1)'(ay);
      b1_1 <= (CW+1)'(ax) - (CW+1)'(bx);
      a2_1 <= (CW+1)'(dy) - (CW+1)'(cy);
      b2_1 <= (CW+1)'(cx) - (CW+1)'(dx);
      m1 <= (2*CW)'(bx) * (2*CW)'(ay);
      m2 <= (2*CW)'(ax) * (2*CW)'(by);
      m3 <= (2*CW)'(dx) * (2*CW)'(cy);
      m4 <= (2*CW)'(cx) * (2*CW)'(dy);

      a1_2 <= a1_1; b1_2 <= b1_1; a2_2 <= a2_1; b2_2 <= b2_1;
      c1_2 <= (2*CW+1)'(m1) - (2*CW+1)'(m2);
      c2_2 <= (2*CW+1)'(m3) - (2*CW+1)'(m4);
      pa <= (2*CW+1)'(a1_1) * (2*CW+1)'(cx1);
      pb <= (2*CW+1)'(b1_1) * (2*CW+1)'(cy1);
      pc <= (2*CW+1)'(a1_1) * (2*CW+1)'(dx1);
      pd <= (2*CW+1)'(b1_1) * (2*CW+1)'(dy1);
      pe <= (2*CW+1)'(a2_1) * (2*CW+1)'(ax1);
      pf <= (2*CW+1)'(b2_1) * (2*CW+1)'(ay1);
      pg <= (2*CW+1)'(a2_1) * (2*CW+1)'(bx1);
      ph <= (2*CW+1)'(b2_1) * (2*CW+1)'(by1);
      pd1 <= (2*CW+2)'(a1_1) * (2*CW+2)'(b2_1);
      pd2 <= (2*CW+2)'(a2_1) * (2*CW+2)'(b1_1);

      sc <= (2*CW+4)'(pa) + (2*CW+4)'(pb) + (2*CW+4)'(c1_2);
      sd <= (2*CW+4)'(pc) + (2*CW+4)'(pd) + (2*CW+4)'(c1_2);
      sa <= (2*CW+4)'(pe) + (2*CW+4)'(pf) + (2*CW+4)'(c2_2);
      sb <= (2*CW+4)'(pg) + (2*CW+4)'(ph) + (2*CW+4)'(c2_2);
      den3 <= DW'(pd1) - DW'(pd2);
      n1 <= (3*CW+2)'(b1_2) * (3*CW+2)'(c2_2);
      n2 <= (3*CW+2)'(b2_2) * (3*CW+2)'(c1_2);
      n3 <= (3*CW+2)'(a2_2) * (3*CW+2)'(c1_2);
      n4 <= (3*CW+2)'(a1_2) * (3*CW+2)'(c2_2);

      hit4     <= !same_cd && !same_ab && (den3 != '0);
      numx4    <= (3*CW+3)'(n1) - (3*CW+3)'(n2);
      numy4    <= (3*CW+3)'(n3) - (3*CW+3)'(n4);
      neg_den4 <= den3[DW-1];
      dmag4    <= den3[DW-1] ? DW'(-den3) : DW'(den3);

      // Rounding: add half the divisor to the magnitude, then truncate.
      hit5  <= hit4;
      negx5 <= numx4[3*CW+2] ^ neg_den4;
      negy5 <= numy4[3*CW+2] ^ neg_den4;
      dmag5 <= dmag4;
      dx5   <= NW'(absx4) + NW'(dmag4 >> 1);
      dy5   <= NW'(absy4) + NW'(dmag4 >> 1);
    end
  end

  assign ctl.valid = v5;
  assign ctl.hit   = hit5;
  assign ctl.neg_x = negx5;
  assign ctl.neg_y = negy5;
  assign den_mag   = dmag5;
  assign dvd_x     = dx5;
  assign dvd_y     = dy5;

endmodule

// File: design/seg_int_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
module seg_int_div
  import seg_int_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [3*COORD_WIDTH+3:0]   dvd,
  input  logic [2*COORD_WIDTH+2:0]   den,
  output logic [COORD_WIDTH:0]       quo
);

  localparam int CW = COORD_WIDTH;
  localparam int QW = CW + 1;
  localparam int DW = 2*CW + 3;

  logic [DW-1:0] rem_s [QW+1];
  logic [QW-1:0] low_s [QW+1];
  logic [QW-1:0] quo_s [QW+1];
  logic [DW-1:0] den_s [QW+1];

  // The high part of the dividend is below the divisor for any crossing
  // point inside the bounding box, so the quotient fits in QW bits.
  assign rem_s[0] = dvd[DW+QW-1:QW];
  assign low_s[0] = dvd[QW-1:0];
  assign quo_s[0] = '0;
  assign den_s[0] = den;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_s[k], low_s[k][QW-1]};
    assign ge    = trial >= {1'b0, den_s[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= ge ? DW'(trial - {1'b0, den_s[k]}) : trial[DW-1:0];
        low_s[k+1] <= {low_s[k][QW-2:0], 1'b0};
        quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
        den_s[k+1] <= den_s[k];
      end
    end
  end

  assign quo = quo_s[QW];

endmodule

// File: design/segment_intersection_int.sv
// Top level of the integer segment intersection pipeline.
// Usage: each input transfer on the s_ side carries two segments (eight
// signed coordinates). Exactly one result transfer leaves on the m_ side for
// each input, in order: m_tuser holds the hit flag and m_tdata the rounded
// crossing point, which reads as zero when there is no hit.
// The pipeline is the multiply and add stages of seg_int_geom, one divider
// stage per quotient bit (COORD_WIDTH+1), and the output register. Throughput
// is one pair per cycle while the receiver does not stall; the divider is
// fully pipelined, one compare and subtract per stage for both coordinates.
// Reset clears every valid bit, so the pipeline comes up empty with m_tvalid
// low. When the receiver holds m_tready low while a result waits, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated, and
// transfers resume at the cycle m_tready returns.
module segment_intersection_int
  import seg_int_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
  // seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y
  input  logic [((8*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // cross_x, cross_y
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]       m_tdata,
  // hit
  output logic                                     m_tuser
);

  localparam int CW  = COORD_WIDTH;
  localparam int QW  = CW + 1;
  localparam int DW  = 2*CW + 3;
  localparam int NW  = 3*CW + 4;
  localparam int OBW = ((2*CW+7)/8)*8;

  logic          en;
  seg_ctl_t      gctl;
  logic [DW-1:0] den_mag;
  logic [NW-1:0] dvd_x, dvd_y;
  logic [QW-1:0] qx, qy;
  seg_ctl_t      ctl_s [QW+1];
  logic [CW-1:0] res_x, res_y;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  seg_int_geom #(.COORD_WIDTH(CW)) u_geom (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .in_data  (s_tdata[8*CW-1:0]),
    .ctl      (gctl),
    .den_mag  (den_mag),
    .dvd_x    (dvd_x),
    .dvd_y    (dvd_y)
  );

  seg_int_div #(.COORD_WIDTH(CW)) u_div_x (
    .clk (clk),
    .en  (en),
    .dvd (dvd_x),
    .den (den_mag),
    .quo (qx)
  );

  seg_int_div #(.COORD_WIDTH(CW)) u_div_y (
    .clk (clk),
    .en  (en),
    .dvd (dvd_y),
    .den (den_mag),
    .quo (qy)
  );

  assign ctl_s[0] = gctl;

  for (genvar k = 0; k < QW; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[k+1] <= '0;
      end else if (en) begin
        ctl_s[k+1] <= ctl_s[k];
      end
    end
  end

  // Apply the sign and clamp to the signed coordinate range.
  function automatic logic [CW-1:0] apply_sign(input logic [QW-1:0] q, input logic neg);
    logic [CW-1:0] r;
    if (neg) begin
      if (q > QW'(1) << (CW-1)) begin
        r = {1'b1, {(CW-1){1'b0}}};
      end else begin
        r = CW'(-q);
      end
    end else begin
      if (q > (QW'(1) << (CW-1)) - QW'(1)) begin
        r = {1'b0, {(CW-1){1'b1}}};
      end else begin
        r = q[CW-1:0];
      end
    end
    return r;
  endfunction

  assign res_x = ctl_s[QW].hit ? apply_sign(qx, ctl_s[QW].neg_x) : '0;
  assign res_y = ctl_s[QW].hit ? apply_sign(qy, ctl_s[QW].neg_y) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ctl_s[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OBW'({res_y, res_x});
      m_tuser <= ctl_s[QW].hit;
    end
  end

endmodule

// File: dv/segment_intersection_int_tb.sv
// Testbench for the integer segment intersection block: table and random pairs.
`timescale 1ns / 100ps

module segment_intersection_int_tb;
  import seg_int_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int IN_W = ((8*CW+7)/8)*8;
  localparam int OUT_W = ((2*CW+7)/8)*8;
  localparam int LATENCY = CW + 7;
  localparam int RANDOM_PAIRS = 1500;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t pt[8];
  } seg_pair_t;

  typedef struct {
    logic   hit;
    coord_t cross_x;
    coord_t cross_y;
  } crossing_t;

  typedef struct {
    coord_t pt[8];
    logic   known;
    logic   hit;
    coord_t cross_x;
    coord_t cross_y;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser;

  crossing_t crossing_q[$];
  int errors = 0;
  int pairs_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;

  segment_intersection_int #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Strictly on one side: neither value is zero and both share a sign.
  function automatic bit one_side(longint p, longint q);
    return p != 0 && q != 0 && ((p < 0) == (q < 0));
  endfunction

  function automatic coord_t round_quot(longint num, longint den, longint half);
    longint adj;
    longint r;
    adj = (num < 0) ? num - half : num + half;
    r = adj / den;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return coord_t'(r);
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t sp);
    crossing_t res;
    longint ax, ay, bx, by, cx, cy, dx, dy;
    longint a1, b1, c1, a2, b2, c2, den, half;
    ax = sp.pt[0]; ay = sp.pt[1]; bx = sp.pt[2]; by = sp.pt[3];
    cx = sp.pt[4]; cy = sp.pt[5]; dx = sp.pt[6]; dy = sp.pt[7];
    res = '{hit: 1'b0, cross_x: '0, cross_y: '0};
    a1 = by - ay; b1 = ax - bx; c1 = bx * ay - ax * by;
    if (one_side(a1*cx + b1*cy + c1, a1*dx + b1*dy + c1)) return res;
    a2 = dy - cy; b2 = cx - dx; c2 = dx * cy - cx * dy;
    if (one_side(a2*ax + b2*ay + c2, a2*bx + b2*by + c2)) return res;
    den = a1 * b2 - a2 * b1;
    if (den == 0) return res;
    half = (den < 0) ? (-den) / 2 : den / 2;
    res.hit = 1'b1;
    res.cross_x = round_quot(b1*c2 - b2*c1, den, half);
    res.cross_y = round_quot(a2*c1 - a1*c2, den, half);
    return res;
  endfunction

  // Leaves s_tvalid high after the transfer; the next call or the caller lowers it.
  task automatic send_pair(seg_pair_t sp, crossing_t want);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    for (int i = 0; i < 8; i++) s_tdata[i*CW +: CW] = sp.pt[i];
    s_tvalid <= 1'b1;
    crossing_q.push_back(want);
    do @(posedge clk); while (!s_tready);
    pairs_sent++;
    @(negedge clk);
  endtask

  function automatic seg_pair_t random_pair();
    seg_pair_t sp;
    int span;
    // Mostly small boxes so crossings are common; sometimes full range.
    case ($urandom_range(0, 3))
      0: span = 32767;
      1: span = 64;
      default: span = 2000;
    endcase
    for (int i = 0; i < 8; i++) begin
      if (span == 32767) sp.pt[i] = coord_t'($urandom);
      else sp.pt[i] = coord_t'($urandom_range(0, 2*span) - span);
    end
    // Force parallel segments now and then.
    if ($urandom_range(0, 15) == 0 && span != 32767) begin
      sp.pt[6] = sp.pt[4] + (sp.pt[2] - sp.pt[0]);
      sp.pt[7] = sp.pt[5] + (sp.pt[3] - sp.pt[1]);
    end
    return sp;
  endfunction

  // Result checker; the receiver stalls at random.
  initial begin
    crossing_t want;
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_seen++;
      if (crossing_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        want = crossing_q.pop_front();
        if (m_tuser !== want.hit) begin
          $error("hit: expected %0b actual %0b", want.hit, m_tuser);
          errors++;
        end
        if (m_tuser) hits_seen++;
        if ($signed(m_tdata[CW-1:0]) !== want.cross_x) begin
          $error("cross_x: expected %0d actual %0d", want.cross_x,
                 $signed(m_tdata[CW-1:0]));
          errors++;
        end
        if ($signed(m_tdata[2*CW-1:CW]) !== want.cross_y) begin
          $error("cross_y: expected %0d actual %0d", want.cross_y,
                 $signed(m_tdata[2*CW-1:CW]));
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    table_row_t rows[$];
    seg_pair_t sp;
    crossing_t want;
    int wait_cycles;
    rows = '{
      // Simple cross at the origin.
      '{'{-10, 0, 10, 0, 0, -10, 0, 10}, 1, 1, 0, 0},
      // Far apart on one side.
      '{'{0, 0, 10, 0, 0, 5, 10, 6}, 1, 0, 0, 0},
      // Parallel and collinear.
      '{'{0, 0, 10, 10, 0, 1, 10, 11}, 1, 0, 0, 0},
      '{'{0, 0, 10, 0, 5, 0, 20, 0}, 1, 0, 0, 0},
      // Endpoint touching the other line.
      '{'{0, 0, 10, 0, 5, 0, 5, 10}, 1, 1, 5, 0},
      // Degenerate point segments.
      '{'{3, 3, 3, 3, 3, 3, 3, 3}, 1, 0, 0, 0},
      '{'{3, 3, 3, 3, 0, 0, 6, 6}, 1, 0, 0, 0},
      // Corner extremes: crossing diagonals and edges at the range limits.
      '{'{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}, 0, 0, 0, 0},
      '{'{32767, 32767, 32767, -32768, -32768, 0, 32767, 0}, 1, 1, 32767, 0},
      '{'{-32768, -32768, -32768, 32767, -32768, 0, 32767, 0}, 1, 1, -32768, 0},
      // Half-unit crossings exercise rounding away from zero, then degenerate and full-range cases.
      '{'{0, 0, 1, 1, 0, 1, 1, 0}, 0, 0, 0, 0},
      '{'{0, 0, -1, -1, 0, -1, -1, 0}, 0, 0, 0, 0},
      '{'{0, 0, 3, 1, 0, 1, 3, 0}, 0, 0, 0, 0},
      '{'{-1, 0, -1, 0, 0, 0, 0, 0}, 0, 0, 0, 0},
      '{'{-32768, 0, 32767, 1, 0, -32768, 1, 32767}, 0, 0, 0, 0},
      '{'{-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767}, 1, 0, 0, 0}
    };
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[r]) begin
      for (int i = 0; i < 8; i++) sp.pt[i] = rows[r].pt[i];
      if (rows[r].known)
        want = '{hit: rows[r].hit, cross_x: rows[r].cross_x, cross_y: rows[r].cross_y};
      else
        want = predict_crossing(sp);
      send_pair(sp, want);
    end
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      // Once midway, hold off until the pipeline has drained.
      if (n == RANDOM_PAIRS / 2) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
        wait_cycles = 0;
        while (crossing_q.size() != 0 && wait_cycles < 100000) begin
          @(negedge clk);
          wait_cycles++;
        end
      end
      sp = random_pair();
      send_pair(sp, predict_crossing(sp));
    end
    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (crossing_q.size() != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (2 * LATENCY) @(negedge clk);
    if (crossing_q.size() != 0) begin
      $error("%0d results never arrived", crossing_q.size());
      errors++;
    end
    $display("Sent %0d segment pairs (table and random), checked %0d results, %0d hits.",
             pairs_sent, results_seen, hits_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
